// ----- design/lzwd_pkg.sv -----
// Shared constants and types of the LZW decompression unit.
`default_nettype none
package lzwd_pkg;
   localparam int MAX_CODE_WIDTH = 16;
   localparam int INIT_BITS      = 9;
   localparam int CODE_W         = MAX_CODE_WIDTH;
   localparam int NFC_W          = MAX_CODE_WIDTH + 1;
   localparam int CNT_W          = 17;
   localparam int GRP_W          = MAX_CODE_WIDTH * 8;
   localparam int FILL_W         = 5;
   localparam int OFF_W          = 8;
   localparam int CW_W           = 5;
   localparam int TABLE_DEPTH    = 1 << MAX_CODE_WIDTH;
   localparam int STACK_DEPTH    = 65536;

   localparam logic [CODE_W-1:0] FIRST_CODE = CODE_W'(257);
   localparam logic [CODE_W-1:0] CLEAR_CODE = CODE_W'(256);
   localparam logic [CW_W-1:0]   INIT_CW    = CW_W'(INIT_BITS);
   localparam logic [CW_W-1:0]   TOP_CW     = CW_W'(MAX_CODE_WIDTH);

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_PULL = 1'b1;

   localparam logic REG_MAX_CODE_BITS = 1'b0;
   localparam logic REG_BLOCK_MODE    = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] comp_byte;
      logic       end_of_input;
   } item_type;

   typedef struct packed {
      logic        en;
      logic        idx;
      logic [31:0] data;
   } cfg_wr_type;

   typedef struct packed {
      logic [4:0] max_code_bits;
      logic       block_mode;
   } cfg_rd_type;

   typedef struct packed {
      logic       bad_code;
      logic       stream_done;
      logic       accepted;
      logic       need_input;
      logic       out_valid;
      logic [7:0] out_byte;
   } rsp_type;
endpackage
`default_nettype wire

// ----- design/lzwd_front.sv -----
// Input side: accepts request transfers, classifies them and queues them for the core.
`default_nettype none
module lzwd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,   // comp_byte
   input  wire logic              req_tuser,   // func
   input  wire logic              req_tlast,   // end_of_input
   output logic                   item_valid,
   output lzwd_pkg::item_type     item,
   input  wire logic              item_pop
);
   import lzwd_pkg::*;

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   new_item;

   always_comb begin
      new_item.func         = (req_tuser == FUNC_PULL) ? FUNC_PULL : FUNC_PUSH;
      new_item.comp_byte    = req_tdata;
      new_item.end_of_input = req_tlast & (req_tuser == FUNC_PUSH);
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid & req_tready;
   assign item_valid = (count_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (item_pop & item_valid);
      count_in  = count_ff + {1'b0, push} - {1'b0, item_pop & item_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end
endmodule
`default_nettype wire

// ----- design/lzwd_core.sv -----
// Decode engine: group buffer, string table, string stack and result register.
`default_nettype none
module lzwd_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 item_valid,
   input  wire lzwd_pkg::item_type   item,
   output logic                      item_pop,
   input  wire lzwd_pkg::cfg_wr_type cfg_wr,
   output lzwd_pkg::cfg_rd_type      cfg_rd,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output lzwd_pkg::rsp_type         rsp
);
   import lzwd_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_POP  = 2'd1;
   localparam logic [1:0] S_WALK = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [GRP_W-1:0]  grp_ff, grp_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CW_W-1:0]   cw_ff, cw_in;
   logic [NFC_W-1:0]  nfc_ff, nfc_in;
   logic [NFC_W-1:0]  curmax_ff, curmax_in;
   logic [CODE_W-1:0] prev_ff, prev_in;
   logic [7:0]        fin_ff, fin_in;
   logic              clrp_ff, clrp_in;
   logic              first_ff, first_in;
   logic              ended_ff, ended_in;
   logic              halt_ff, halt_in;
   logic [4:0]        mcb_ff, mcb_in;
   logic              bm_ff, bm_in;
   logic [CODE_W-1:0] incode_ff, incode_in;
   logic [CODE_W-1:0] walk_ff, walk_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [CODE_W-1:0] pfx_mem [TABLE_DEPTH];
   logic [7:0]        sfx_mem [TABLE_DEPTH];
   logic [7:0]        stk_mem [STACK_DEPTH];
   logic [CODE_W-1:0] tbl_raddr, tbl_waddr, tbl_wpfx, pfx_rd_ff;
   logic [7:0]        tbl_wsfx, sfx_rd_ff, stk_wdata, stk_rd_ff;
   logic              tbl_we, stk_we;
   logic [15:0]       stk_waddr, stk_raddr;

   logic [4:0]        eff;
   logic [NFC_W-1:0]  eff_size;

   assign eff      = (mcb_ff < INIT_CW) ? INIT_CW : ((mcb_ff > TOP_CW) ? TOP_CW : mcb_ff);
   assign eff_size = NFC_W'(1) << eff;

   function automatic logic [NFC_W-1:0] limit_for(input logic [CW_W-1:0] w,
                                                 input logic [4:0] b);
      logic [NFC_W-1:0] r;
      if (w >= b) r = NFC_W'(1) << b;
      else        r = (NFC_W'(1) << w) - NFC_W'(1);
      return r;
   endfunction

   always_comb begin
      logic [CODE_W-1:0] code;
      logic [CODE_W-1:0] end_c;
      logic              do_end, do_chk, do_halt, load, grow;
      rsp_type           r;

      state_in = state_ff;   grp_in = grp_ff;       fill_in = fill_ff;
      off_in = off_ff;       cnt_in = cnt_ff;       cw_in = cw_ff;
      nfc_in = nfc_ff;       curmax_in = curmax_ff; prev_in = prev_ff;
      fin_in = fin_ff;       clrp_in = clrp_ff;     first_in = first_ff;
      ended_in = ended_ff;   halt_in = halt_ff;     mcb_in = mcb_ff;
      bm_in = bm_ff;         incode_in = incode_ff; walk_in = walk_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      item_pop = 1'b0;
      tbl_raddr = walk_ff;   tbl_we = 1'b0;  tbl_waddr = nfc_ff[CODE_W-1:0];
      tbl_wpfx = prev_ff;    tbl_wsfx = fin_ff;
      stk_we = 1'b0;         stk_waddr = cnt_ff[15:0];  stk_wdata = fin_ff;
      stk_raddr = cnt_ff[15:0] - 16'd1;
      code = '0;  end_c = '0;
      do_end = 1'b0; do_chk = 1'b0; do_halt = 1'b0; load = 1'b0; grow = 1'b0;
      r = '0;

      case (state_ff)
         S_IDLE: begin
            if (item_valid && (!rsp_valid_ff || rsp_ready)) begin
               item_pop = 1'b1;
               if (item.func == FUNC_PUSH) begin
                  if (!halt_ff && !ended_ff && (fill_ff < cw_ff)) begin
                     grp_in[{fill_ff[3:0], 3'b000} +: 8] = item.comp_byte;
                     fill_in = fill_ff + FILL_W'(1);
                     off_in  = '0;
                     if (item.end_of_input) ended_in = 1'b1;
                     r.accepted = 1'b1;
                  end
                  load = 1'b1;
               end else if (halt_ff) begin
                  load = 1'b1;
               end else if (cnt_ff != '0) begin
                  cnt_in   = cnt_ff - CNT_W'(1);
                  state_in = S_POP;
               end else if (fill_ff != '0 && (fill_ff >= cw_ff || ended_ff)) begin
                  for (int i = 0; i < CODE_W; i++) begin
                     code[i] = (CW_W'(i) < cw_ff) ? grp_ff[i] : 1'b0;
                  end
                  grp_in = grp_ff >> cw_ff;
                  off_in = off_ff + OFF_W'(cw_ff);
                  if (!first_ff) begin
                     first_in    = 1'b1;
                     prev_in     = code;
                     fin_in      = code[7:0];
                     r.out_byte  = code[7:0];
                     r.out_valid = 1'b1;
                     do_chk      = 1'b1;
                     load        = 1'b1;
                  end else if (bm_ff && code == CLEAR_CODE && !clrp_ff) begin
                     clrp_in      = 1'b1;
                     nfc_in       = NFC_W'(CLEAR_CODE);
                     cw_in        = INIT_CW;
                     curmax_in    = (NFC_W'(1) << INIT_BITS) - NFC_W'(1);
                     grp_in       = '0;
                     fill_in      = '0;
                     off_in       = '0;
                     r.need_input = ~ended_ff;
                     load         = 1'b1;
                  end else begin
                     clrp_in   = 1'b0;
                     incode_in = code;
                     end_c     = code;
                     if ({1'b0, code} >= nfc_ff) begin
                        if (cnt_ff[CNT_W-1]) begin
                           do_halt = 1'b1;
                        end else begin
                           stk_we = 1'b1;
                           cnt_in = cnt_ff + CNT_W'(1);
                        end
                        end_c = prev_ff;
                     end
                     if (!do_halt) begin
                        if (end_c >= CLEAR_CODE) begin
                           tbl_raddr = end_c;
                           walk_in   = end_c;
                           state_in  = S_WALK;
                        end else begin
                           do_end = 1'b1;
                        end
                     end
                  end
               end else begin
                  r.need_input = ~ended_ff;
                  load         = 1'b1;
               end
            end
         end
         S_POP: begin
            r.out_byte  = stk_rd_ff;
            r.out_valid = 1'b1;
            load        = 1'b1;
            state_in    = S_IDLE;
         end
         S_WALK: begin
            if (pfx_rd_ff == walk_ff || cnt_ff[CNT_W-1]) begin
               do_halt = 1'b1;
            end else begin
               stk_we    = 1'b1;
               stk_wdata = sfx_rd_ff;
               cnt_in    = cnt_ff + CNT_W'(1);
               if (pfx_rd_ff >= CLEAR_CODE) begin
                  tbl_raddr = pfx_rd_ff;
                  walk_in   = pfx_rd_ff;
               end else begin
                  end_c  = pfx_rd_ff;
                  do_end = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (do_end) begin
         if (cnt_in[CNT_W-1]) begin
            do_halt = 1'b1;
         end else begin
            fin_in      = end_c[7:0];
            r.out_byte  = end_c[7:0];
            r.out_valid = 1'b1;
            if (nfc_in < eff_size) begin
               tbl_we    = 1'b1;
               tbl_waddr = nfc_in[CODE_W-1:0];
               tbl_wpfx  = prev_in;
               tbl_wsfx  = end_c[7:0];
               nfc_in    = nfc_in + NFC_W'(1);
            end
            prev_in  = incode_in;
            do_chk   = 1'b1;
            load     = 1'b1;
            state_in = S_IDLE;
         end
      end

      if (do_halt) begin
         halt_in     = 1'b1;
         cnt_in      = '0;
         r.out_valid = 1'b0;
         r.out_byte  = '0;
         load        = 1'b1;
         state_in    = S_IDLE;
      end

      if (do_chk) begin
         grow = nfc_in > curmax_in;
         if (grow || ({1'b0, off_in} + 9'(cw_in) - 9'd1 >= {1'b0, fill_in, 3'b000})) begin
            if (grow && cw_in < TOP_CW) begin
               cw_in     = cw_in + CW_W'(1);
               curmax_in = limit_for(cw_in, eff);
            end
            grp_in  = '0;
            fill_in = '0;
            off_in  = '0;
         end
      end

      if (load) begin
         r.bad_code    = halt_in;
         r.stream_done = ended_in && fill_in == '0 && cnt_in == '0 && !halt_in;
         rsp_in        = r;
         rsp_valid_in  = 1'b1;
      end

      if (cfg_wr.en) begin
         case (cfg_wr.idx)
            REG_MAX_CODE_BITS: mcb_in = cfg_wr.data[4:0];
            REG_BLOCK_MODE: begin
               bm_in = cfg_wr.data[0];
               if (!first_ff) nfc_in = cfg_wr.data[0] ? NFC_W'(FIRST_CODE) : NFC_W'(CLEAR_CODE);
            end
            default: mcb_in = mcb_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         grp_ff       <= '0;
         fill_ff      <= '0;
         off_ff       <= '0;
         cnt_ff       <= '0;
         cw_ff        <= INIT_CW;
         nfc_ff       <= NFC_W'(FIRST_CODE);
         curmax_ff    <= (NFC_W'(1) << INIT_BITS) - NFC_W'(1);
         prev_ff      <= '0;
         fin_ff       <= '0;
         clrp_ff      <= 1'b0;
         first_ff     <= 1'b0;
         ended_ff     <= 1'b0;
         halt_ff      <= 1'b0;
         mcb_ff       <= 5'd16;
         bm_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grp_ff       <= grp_in;
         fill_ff      <= fill_in;
         off_ff       <= off_in;
         cnt_ff       <= cnt_in;
         cw_ff        <= cw_in;
         nfc_ff       <= nfc_in;
         curmax_ff    <= curmax_in;
         prev_ff      <= prev_in;
         fin_ff       <= fin_in;
         clrp_ff      <= clrp_in;
         first_ff     <= first_in;
         ended_ff     <= ended_in;
         halt_ff      <= halt_in;
         mcb_ff       <= mcb_in;
         bm_ff        <= bm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      incode_ff <= incode_in;
      walk_ff   <= walk_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         pfx_mem[tbl_waddr] <= tbl_wpfx;
         sfx_mem[tbl_waddr] <= tbl_wsfx;
      end
      pfx_rd_ff <= pfx_mem[tbl_raddr];
      sfx_rd_ff <= sfx_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rd_ff <= stk_mem[stk_raddr];
   end

   assign cfg_rd.max_code_bits = mcb_ff;
   assign cfg_rd.block_mode    = bm_ff;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp                  = rsp_ff;
endmodule
`default_nettype wire

// ----- design/lzw_compress_decoder_unit.sv -----
// Top level of the LZW decompression unit: request queue, decode core, register port.
// Push and pull transfers answered from the group buffer are served in the idle state;
// a pull from the string stack goes through the pop state; a code expansion walks the
// string table one hop at a time (one table read port). The result is registered and
// appears in the cycle after the core finishes; two request transfers can queue.
// Reset is synchronous and clears control state; string tables are not cleared.
`default_nettype none
module lzw_compress_decoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // comp_byte
   input  wire logic        req_tuser,   // func
   input  wire logic        req_tlast,   // end_of_input
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // out_byte, need_input, accepted, stream_done,
                                         // bad_code, zero fill
   output logic             rsp_tuser,   // out_valid
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import lzwd_pkg::*;

   logic       item_valid, item_pop;
   item_type   item;
   cfg_wr_type cfg_wr;
   cfg_rd_type cfg_rd;
   rsp_type    rsp;

   lzwd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   assign csr_pready  = 1'b1;
   assign cfg_wr.en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg_wr.idx  = csr_paddr[2];
   assign cfg_wr.data = csr_pwdata;

   always_comb begin
      case (csr_paddr[2])
         REG_MAX_CODE_BITS: csr_prdata = {27'd0, cfg_rd.max_code_bits};
         REG_BLOCK_MODE:    csr_prdata = {31'd0, cfg_rd.block_mode};
         default:           csr_prdata = '0;
      endcase
   end

   lzwd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .cfg_wr     (cfg_wr),
      .cfg_rd     (cfg_rd),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp        (rsp)
   );

   assign rsp_tdata = {4'd0, rsp.bad_code, rsp.stream_done, rsp.accepted,
                       rsp.need_input, rsp.out_byte};
   assign rsp_tuser = rsp.out_valid;
endmodule
`default_nettype wire

// ----- design/lzwd_checker.sv -----
// Port-level checks of the LZW decompression unit, bound to the top level.
`default_nettype none
module lzwd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tuser
);
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_byte_not_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[11] && !rsp_tdata[8] && !rsp_tdata[9])
      else $error("decoded byte with error, need or accept flag");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result pending after reset");
endmodule

bind lzw_compress_decoder_unit lzwd_checker u_lzwd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ----- verif/lzw_compress_decoder_unit_tb.sv -----
// Self-checking LZW decoder testbench: directed table, legal random streams, then a bad-code case.
`timescale 1ns / 1ps
module lzw_compress_decoder_unit_tb;
   import lzwd_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   lzw_compress_decoder_unit u_top (.*);

   typedef struct {
      logic       func;
      logic [7:0] data;
      logic       last;
   } xfer_type;

   typedef struct {
      logic       func;
      logic [7:0] data;
      logic       last;
      bit         typed;
      rsp_type    want;
   } dir_row_type;

   localparam rsp_type R_NONE = '{bad_code:0, stream_done:0, accepted:0, need_input:0,
                                  out_valid:0, out_byte:8'h00};
   localparam rsp_type R_NEED = '{bad_code:0, stream_done:0, accepted:0, need_input:1,
                                  out_valid:0, out_byte:8'h00};
   localparam rsp_type R_ACC  = '{bad_code:0, stream_done:0, accepted:1, need_input:0,
                                  out_valid:0, out_byte:8'h00};
   localparam rsp_type R_FF   = '{bad_code:0, stream_done:0, accepted:0, need_input:0,
                                  out_valid:1, out_byte:8'hFF};

   dir_row_type dir_tab [0:20] = '{
      '{FUNC_PULL, 8'h00, 1'b0, 1'b1, R_NEED},
      '{FUNC_PUSH, 8'hFF, 1'b0, 1'b1, R_ACC},
      '{FUNC_PULL, 8'h00, 1'b0, 1'b1, R_NEED},
      '{FUNC_PUSH, 8'h01, 1'b0, 1'b1, R_ACC},
      '{FUNC_PUSH, 8'h00, 1'b0, 1'b1, R_ACC},
      '{FUNC_PUSH, 8'h00, 1'b0, 1'b1, R_ACC},
      '{FUNC_PUSH, 8'h00, 1'b0, 1'b1, R_ACC},
      '{FUNC_PUSH, 8'h00, 1'b0, 1'b1, R_ACC},
      '{FUNC_PUSH, 8'h00, 1'b0, 1'b1, R_ACC},
      '{FUNC_PUSH, 8'h00, 1'b0, 1'b1, R_ACC},
      '{FUNC_PUSH, 8'h00, 1'b0, 1'b1, R_ACC},
      '{FUNC_PUSH, 8'hAA, 1'b0, 1'b1, R_NONE},
      '{FUNC_PULL, 8'h00, 1'b0, 1'b1, R_FF},
      '{FUNC_PULL, 8'h00, 1'b0, 1'b0, R_NONE},
      '{FUNC_PULL, 8'h00, 1'b0, 1'b0, R_NONE},
      '{FUNC_PULL, 8'h00, 1'b0, 1'b0, R_NONE},
      '{FUNC_PULL, 8'h00, 1'b0, 1'b0, R_NONE},
      '{FUNC_PULL, 8'h00, 1'b0, 1'b0, R_NONE},
      '{FUNC_PULL, 8'h00, 1'b0, 1'b0, R_NONE},
      '{FUNC_PULL, 8'h00, 1'b0, 1'b0, R_NONE},
      '{FUNC_PULL, 8'h00, 1'b0, 1'b0, R_NONE}
   };

   // decoder shadow state
   logic [15:0] pfx_tab [TABLE_DEPTH];
   logic [7:0]  sfx_tab [TABLE_DEPTH];
   bit          entry_ok [TABLE_DEPTH];
   logic [7:0]  str_stack [$];
   logic [7:0]  grp [MAX_CODE_WIDTH];
   int unsigned g_fill, g_off, cw, nfc, prev_code, fin_char, cur_max, m_bits;
   bit          clr_pend, seen_first, in_ended, halted, blk;

   xfer_type    pend_xfers [$];
   rsp_type     want_q [$];
   int          errs;
   int          n_items;
   bit          quiet;

   function automatic int unsigned eff_bits();
      if (m_bits < INIT_BITS) return INIT_BITS;
      if (m_bits > MAX_CODE_WIDTH) return MAX_CODE_WIDTH;
      return m_bits;
   endfunction

   function automatic int unsigned limit_for(int unsigned w);
      return (w >= eff_bits()) ? (1 << eff_bits()) : ((1 << w) - 1);
   endfunction

   function automatic int unsigned grp_byte(int unsigned i);
      return (i < g_fill && i < MAX_CODE_WIDTH) ? grp[i] : 0;
   endfunction

   function automatic int unsigned read_code();
      int unsigned i, win, code;
      i = g_off >> 3;
      win = grp_byte(i) | (grp_byte(i + 1) << 8) | (grp_byte(i + 2) << 16);
      code = (win >> (g_off & 7)) & ((1 << cw) - 1);
      g_off += cw;
      return code;
   endfunction

   function automatic void check_group();
      int usable;
      bit grow;
      usable = int'(g_fill) * 8 - (int'(cw) - 1);
      grow = nfc > cur_max;
      if (grow || int'(g_off) >= usable) begin
         if (grow && cw < MAX_CODE_WIDTH) begin
            cw++;
            cur_max = limit_for(cw);
         end
         g_fill = 0;
         g_off = 0;
      end
   endfunction

   function automatic bit stk_push(int unsigned v);
      if (str_stack.size() >= STACK_DEPTH) return 0;
      str_stack.push_back(v[7:0]);
      return 1;
   endfunction

   function automatic bit expand_code(int unsigned code);
      int unsigned c, idx;
      c = code;
      if (c >= nfc) begin
         if (!stk_push(fin_char)) return 0;
         c = prev_code;
      end
      while (c >= 256) begin
         idx = c & 16'hFFFF;
         if (pfx_tab[idx] == c) return 0;
         if (!stk_push(sfx_tab[idx])) return 0;
         c = pfx_tab[idx];
      end
      fin_char = c & 8'hFF;
      if (!stk_push(fin_char)) return 0;
      if (nfc < (1 << eff_bits())) begin
         idx = nfc & 16'hFFFF;
         pfx_tab[idx] = prev_code[15:0];
         sfx_tab[idx] = fin_char[7:0];
         entry_ok[idx] = 1;
         nfc++;
      end
      prev_code = code & 16'hFFFF;
      return 1;
   endfunction

   function automatic rsp_type decode_step(logic f, logic [7:0] b, logic eoi);
      rsp_type r;
      int unsigned code;
      r = R_NONE;
      if (f == FUNC_PUSH) begin
         if (!halted && !in_ended && g_fill < cw && g_fill < MAX_CODE_WIDTH) begin
            grp[g_fill] = b;
            g_fill++;
            g_off = 0;
            if (eoi) in_ended = 1;
            r.accepted = 1;
         end
      end else if (!halted) begin
         if (str_stack.size() > 0) begin
            r.out_byte = str_stack.pop_back();
            r.out_valid = 1;
         end else if (g_fill > 0 && (g_fill >= cw || in_ended)) begin
            code = read_code();
            if (!seen_first) begin
               seen_first = 1;
               prev_code = code;
               fin_char = code & 8'hFF;
               r.out_byte = fin_char[7:0];
               r.out_valid = 1;
               check_group();
            end else if (blk && code == CLEAR_CODE && !clr_pend) begin
               clr_pend = 1;
               nfc = 256;
               cw = INIT_BITS;
               cur_max = (1 << INIT_BITS) - 1;
               g_fill = 0;
               g_off = 0;
               r.need_input = !in_ended;
            end else begin
               clr_pend = 0;
               if (!expand_code(code)) begin
                  halted = 1;
                  str_stack.delete();
               end else begin
                  r.out_byte = str_stack.pop_back();
                  r.out_valid = 1;
                  check_group();
               end
            end
         end else begin
            r.need_input = !in_ended;
         end
      end
      r.stream_done = in_ended && g_fill == 0 && str_stack.size() == 0 && !halted;
      r.bad_code = halted;
      return r;
   endfunction

   function automatic void add_xfer(logic f, logic [7:0] b, logic eoi, bit typed,
                                    rsp_type want);
      rsp_type r;
      r = decode_step(f, b, eoi);
      pend_xfers.push_back('{f, b, eoi});
      want_q.push_back(typed ? want : r);
      n_items++;
   endfunction

   // pack codes LSB first into one group, push it, then pull until it is used up
   function automatic void add_group(int unsigned codes [$], bit short_last);
      logic [127:0] bits;
      int unsigned  nbytes;
      bits = '0;
      foreach (codes[k]) bits |= 128'(codes[k]) << (k * cw);
      nbytes = short_last ? 2 : cw;
      for (int i = 0; i < nbytes; i++)
         add_xfer(FUNC_PUSH, bits[8*i +: 8], short_last && i == nbytes - 1, 0, R_NONE);
      if ($urandom_range(0, 9) == 0)
         add_xfer(FUNC_PUSH, 8'($urandom), 1'($urandom), 0, R_NONE);
      while ((g_fill > 0 || str_stack.size() > 0) && !halted)
         add_xfer(FUNC_PULL, 8'($urandom), 1'b0, 0, R_NONE);
   endfunction

   function automatic void add_random_group();
      int unsigned codes [$];
      int unsigned l_nfc, c, r;
      bit          l_first, l_pend;
      l_nfc = nfc;
      l_first = seen_first;
      l_pend = clr_pend;
      for (int k = 0; k < 8; k++) begin
         r = $urandom_range(0, 99);
         c = $urandom_range(0, 255);
         if (l_first && !l_pend) begin
            if (r < 6 && blk) begin
               codes.push_back(CLEAR_CODE);
               break;
            end else if (r < 18 && l_nfc < (1 << cw)) begin
               c = l_nfc;
            end else if (r >= 50 && l_nfc > 256) begin
               c = $urandom_range(256, l_nfc - 1);
               if (!entry_ok[c] || (c == CLEAR_CODE &&
                                    (blk || pfx_tab[CLEAR_CODE] == CLEAR_CODE)))
                  c = $urandom_range(0, 255);
            end
         end
         codes.push_back(c);
         if (!l_first) begin
            l_first = 1;
         end else begin
            l_pend = 0;
            if (l_nfc < (1 << eff_bits())) l_nfc++;
         end
         if (l_nfc > cur_max) break;
      end
      if ($urandom_range(0, 9) == 0) add_xfer(FUNC_PULL, 8'h00, 1'b0, 0, R_NONE);
      add_group(codes, 0);
   endfunction

   task automatic write_reg(logic idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      if (idx == REG_MAX_CODE_BITS) begin
         m_bits = value & 32'h1F;
      end else begin
         blk = value[0];
         if (!seen_first) nfc = blk ? FIRST_CODE : 256;
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_all();
      xfer_type x;
      int       gap;
      while (pend_xfers.size() > 0) begin
         x = pend_xfers.pop_front();
         gap = pick_gap();
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1;
         req_tuser <= x.func;
         req_tdata <= x.data;
         req_tlast <= x.last;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 0;
   endtask

   task automatic drain();
      while (want_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errs++;
      end
   endtask

   always begin
      clock = 1;
      #4;
      clock = 0;
      #4;
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (want_q.size() == 0) begin
            $error("unexpected result transfer");
            errs++;
         end else begin
            want = want_q.pop_front();
            check_field("out_byte", want.out_byte, rsp_tdata[7:0]);
            check_field("out_valid", want.out_valid, rsp_tuser);
            check_field("need_input", want.need_input, rsp_tdata[8]);
            check_field("accepted", want.accepted, rsp_tdata[9]);
            check_field("stream_done", want.stream_done, rsp_tdata[10]);
            check_field("bad_code", want.bad_code, rsp_tdata[11]);
         end
      end
   end

   initial begin
      int n;
      rsp_tready = 0;
      @(negedge reset);
      forever begin
         n = pick_gap();
         if (n > 0) begin
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
      end
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int unsigned mbits_set [6] = '{16, 9, 12, 0, 31, 16};
      bit          blk_set [6]   = '{1, 1, 0, 1, 0, 1};
      int unsigned codes [$];
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tuser = 0;
      req_tlast = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      errs = 0;
      n_items = 0;
      quiet = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         pfx_tab[i] = 0;
         sfx_tab[i] = 0;
         entry_ok[i] = 0;
      end
      g_fill = 0;
      g_off = 0;
      cw = INIT_BITS;
      cur_max = (1 << INIT_BITS) - 1;
      nfc = FIRST_CODE;
      prev_code = 0;
      fin_char = 0;
      m_bits = 16;
      blk = 1;
      clr_pend = 0;
      seen_first = 0;
      in_ended = 0;
      halted = 0;
      repeat (10) @(posedge clock);
      reset <= 0;

      write_reg(REG_BLOCK_MODE, 0);
      write_reg(REG_BLOCK_MODE, 1);
      foreach (dir_tab[i])
         add_xfer(dir_tab[i].func, dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed,
                  dir_tab[i].want);
      send_all();
      drain();

      for (int p = 0; p < 6; p++) begin
         write_reg(REG_MAX_CODE_BITS, mbits_set[p]);
         write_reg(REG_BLOCK_MODE, blk_set[p]);
         quiet = (p == 2);
         while (n_items < 21 + (p + 1) * 180) add_random_group();
         send_all();
         drain();
      end

      // end of stream: build a self-referencing entry at the clear code, then hit it
      write_reg(REG_MAX_CODE_BITS, 16);
      write_reg(REG_BLOCK_MODE, 1);
      quiet = 0;
      codes = '{65};
      add_group(codes, 0);
      codes = '{CLEAR_CODE};
      add_group(codes, 0);
      codes = '{CLEAR_CODE, CLEAR_CODE};
      add_group(codes, 0);
      codes = '{66};
      add_group(codes, 0);
      send_all();
      drain();
      write_reg(REG_BLOCK_MODE, 0);
      codes = '{CLEAR_CODE};
      add_group(codes, 1);
      add_xfer(FUNC_PULL, 8'h00, 1'b0, 0, R_NONE);
      add_xfer(FUNC_PUSH, 8'h5A, 1'b1, 0, R_NONE);
      add_xfer(FUNC_PULL, 8'h00, 1'b0, 0, R_NONE);
      send_all();
      drain();

      if (errs == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
